>>> design/bbrm_pkg.sv
// Package for the button box report mapper.
// Holds the request and report types, register indexes and fixed levels.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps

package bbrm_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAN_PARASOL_DASH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAN_SLIGHT_SIDE  = 1'd1;

    localparam int DIR_LEFT  = 0;
    localparam int DIR_RIGHT = 1;
    localparam int DIR_UP    = 2;
    localparam int DIR_DOWN  = 3;

    localparam logic [7:0] AXIS_CENTRE   = 8'd128;
    localparam logic [7:0] TRIGGER_FULL  = 8'd140;
    localparam logic [7:0] TRIGGER_MID   = 8'd94;
    localparam logic [7:0] TRIGGER_LIGHT = 8'd49;
    localparam logic [7:0] TRIGGER_OFF   = 8'd0;

    typedef struct packed {
        logic [3:0] directions;
        logic [3:0] c_buttons;
        logic [3:0] modifiers;
        logic [1:0] shoulders;
        logic [5:0] face_buttons;
    } snap_t;

    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_y;
        logic [7:0] cstick_x;
        logic [7:0] cstick_y;
        logic [3:0] dpad;
        logic [7:0] trigger_left;
        logic [7:0] trigger_right;
        logic [7:0] report_buttons;
    } report_t;

    typedef struct packed {
        logic ban_parasol_dash;
        logic ban_slight_side;
    } cfg_t;

    // Axis value is the centre plus an offset, optionally mirrored about zero modulo 256.
    function automatic logic [7:0] axis_value(input logic signed [7:0] offset,
                                              input logic mirror);
        logic [7:0] v;
        v = AXIS_CENTRE + offset;
        return mirror ? 8'(8'd0 - v) : v;
    endfunction

endpackage

>>> design/bbrm_ifs.sv
// Request and report channel interfaces for the button box report mapper.
// Each carries valid, ready and a payload struct from bbrm_pkg.
`timescale 1ns / 1ps

interface bbrm_snap_if;
    logic           valid;
    logic           ready;
    bbrm_pkg::snap_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bbrm_report_if;
    logic              valid;
    logic              ready;
    bbrm_pkg::report_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/bbrm_lockout.sv
// Opposing-direction lockout state for the button box report mapper.
// Keeps the previous directions and lockout flags; uses bbrm_pkg.
`timescale 1ns / 1ps

module bbrm_lockout (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       update,
    input  logic [3:0] directions,
    output logic [3:0] active
);

    logic [3:0] prior_reg;
    logic [3:0] prior_next;
    logic [3:0] locked_reg;
    logic [3:0] locked_next;

    localparam int L = bbrm_pkg::DIR_LEFT;
    localparam int R = bbrm_pkg::DIR_RIGHT;
    localparam int U = bbrm_pkg::DIR_UP;
    localparam int D = bbrm_pkg::DIR_DOWN;

    always_comb
    begin
        logic both_h;
        logic both_v;
        logic [3:0] lock;
        both_h = directions[L] && directions[R];
        both_v = directions[U] && directions[D];
        lock = locked_reg;
        lock[L] = lock[L] | (prior_reg[L] && both_h && !prior_reg[R]);
        lock[R] = lock[R] | (prior_reg[R] && both_h && !prior_reg[L]);
        lock[U] = lock[U] | (prior_reg[U] && both_v && !prior_reg[D]);
        lock[D] = lock[D] | (prior_reg[D] && both_v && !prior_reg[U]);
        locked_next = lock & directions;
        prior_next = directions;
        active = directions & ~locked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg  <= 4'd0;
            locked_reg <= 4'd0;
        end
        else if (update)
        begin
            prior_reg  <= prior_next;
            locked_reg <= locked_next;
        end
    end

endmodule

>>> design/bbrm_mapper.sv
// Coordinate table and report assembly for the button box report mapper.
// Purely combinational; uses the types and axis function of bbrm_pkg.
`timescale 1ns / 1ps

module bbrm_mapper (
    input  logic              [3:0] active,
    input  bbrm_pkg::snap_t         snap,
    input  bbrm_pkg::cfg_t          cfg,
    output bbrm_pkg::report_t       report
);

    always_comb
    begin
        logic left, right, up, down;
        logic vertical, horizontal;
        logic c_l, c_r, c_u, c_d;
        logic mx, my, ms, ls, sl, sr, bb;
        logic cv, ch;
        logic signed [7:0] dx, dy, cdx, cdy;

        left  = active[bbrm_pkg::DIR_LEFT];
        right = active[bbrm_pkg::DIR_RIGHT];
        up    = active[bbrm_pkg::DIR_UP];
        down  = active[bbrm_pkg::DIR_DOWN];
        c_l = snap.c_buttons[0];
        c_r = snap.c_buttons[1];
        c_u = snap.c_buttons[2];
        c_d = snap.c_buttons[3];
        mx = snap.modifiers[0];
        my = snap.modifiers[1];
        ms = snap.modifiers[2];
        ls = snap.modifiers[3];
        sl = snap.shoulders[0];
        sr = snap.shoulders[1];
        bb = snap.face_buttons[1];
        vertical   = up || down;
        horizontal = left || right;

        dx = 8'sd0;
        dy = 8'sd0;
        if (vertical && horizontal)
        begin
            if (sl || sr)
            begin
                if (mx == my)
                begin
                    dx = 8'sd56;
                    dy = up ? 8'sd56 : 8'sd55;
                end
                else if (mx)                            begin dx = 8'sd51; dy = 8'sd30; end
                else if (cfg.ban_parasol_dash && up)    begin dx = 8'sd70; dy = 8'sd38; end
                else                                    begin dx = 8'sd68; dy = 8'sd40; end
            end
            else if (bb && mx != my)
            begin
                if (mx)
                begin
                    if (c_d)      begin dx = 8'sd73; dy = 8'sd36; end
                    else if (c_l) begin dx = 8'sd68; dy = 8'sd42; end
                    else if (c_u) begin dx = 8'sd59; dy = 8'sd43; end
                    else if (c_r) begin dx = 8'sd51; dy = 8'sd43; end
                    else          begin dx = 8'sd73; dy = 8'sd31; end
                end
                else
                begin
                    if (c_d)      begin dx = 8'sd36; dy = 8'sd70; end
                    else if (c_l) begin dx = 8'sd42; dy = 8'sd68; end
                    else if (c_u) begin dx = 8'sd47; dy = 8'sd64; end
                    else if (c_r) begin dx = 8'sd47; dy = 8'sd57; end
                    else          begin dx = 8'sd31; dy = 8'sd73; end
                end
            end
            else if (mx != my)
            begin
                if (mx)
                begin
                    if (c_d)      begin dx = 8'sd56; dy = 8'sd29; end
                    else if (c_l) begin dx = 8'sd63; dy = 8'sd39; end
                    else if (c_u) begin dx = 8'sd56; dy = 8'sd41; end
                    else if (c_r) begin dx = 8'sd49; dy = 8'sd42; end
                    else          begin dx = 8'sd59; dy = 8'sd25; end
                end
                else
                begin
                    if (c_d)      begin dx = 8'sd29; dy = 8'sd56; end
                    else if (c_l) begin dx = 8'sd39; dy = 8'sd63; end
                    else if (c_u) begin dx = 8'sd41; dy = 8'sd56; end
                    else if (c_r) begin dx = 8'sd51; dy = 8'sd61; end
                    else          begin dx = 8'sd25; dy = 8'sd59; end
                end
            end
            else
            begin
                dx = 8'sd56;
                dy = 8'sd56;
            end
        end
        else if (horizontal)
        begin
            if (mx == my)
                dx = 8'sd80;
            else if (mx)
                dx = (left && right) ? 8'sd80 : 8'sd53;
            else
                dx = ((cfg.ban_slight_side && bb) || (left && right)) ? 8'sd80 : 8'sd27;
        end
        else if (vertical)
        begin
            if (mx == my)
                dy = 8'sd80;
            else if (mx)
                dy = 8'sd43;
            else
                dy = 8'sd59;
        end

        cv = c_u != c_d;
        ch = c_l != c_r;
        cdx = 8'sd0;
        cdy = 8'sd0;
        if (mx && my)
        begin
            cdx = 8'sd0;
            cdy = 8'sd0;
        end
        else if (cv && ch)
        begin
            cdx = 8'sd42;
            cdy = 8'sd68;
        end
        else if (ch)
        begin
            if (mx)
            begin
                cdx = 8'sd67;
                cdy = up ? 8'sd25 : -8'sd25;
            end
            else
            begin
                cdx = 8'sd80;
                cdy = 8'sd0;
            end
        end
        else if (cv)
        begin
            cdy = 8'sd80;
        end

        report.stick_x  = bbrm_pkg::axis_value(dx, horizontal && !right);
        report.stick_y  = bbrm_pkg::axis_value(dy, vertical && !up);
        report.cstick_x = bbrm_pkg::axis_value(cdx, ch && c_l);
        report.cstick_y = bbrm_pkg::axis_value(cdy, cv && c_d);
        report.dpad     = (mx && my) ? {c_r, c_u, c_l, c_d} : 4'd0;
        report.trigger_left  = sl ? bbrm_pkg::TRIGGER_FULL :
                               ms ? bbrm_pkg::TRIGGER_MID :
                               ls ? bbrm_pkg::TRIGGER_LIGHT : bbrm_pkg::TRIGGER_OFF;
        report.trigger_right = sr ? bbrm_pkg::TRIGGER_FULL : bbrm_pkg::TRIGGER_OFF;
        report.report_buttons = {snap.face_buttons[5], sr, sl, snap.face_buttons[4:0]};
    end

endmodule

>>> design/button_box_report_mapper_top.sv
// Top level of the button box report mapper.
// Instantiates bbrm_lockout and bbrm_mapper; uses bbrm_pkg and bbrm_ifs.
//
// Usage. Each request on snapshot carries one polling snapshot of the
// buttons; each report on report carries the controller report for it.
// Both channels move a request when valid and ready are high together.
// A request lands in an input register; the table is evaluated from it
// combinationally, and when the output can advance the lockout flags are
// updated and the report is loaded into the output register. One request
// is taken every cycle while the receiver keeps up.
// The two register stages form a pipeline: when the receiver stalls, the
// report holds and the input register still takes one more request before
// ready falls. The configuration port writes a register at any edge with
// cfg_wr_en high; it is meant to be used while the block is idle.
// Reset clears both stages, the lockout history, and sets both ban
// registers to one.
`timescale 1ns / 1ps

module button_box_report_mapper_top (
    input  logic                                clk,
    input  logic                                rst_n,
    bbrm_snap_if.sink                           snapshot,
    bbrm_report_if.source                       report,
    input  logic                                cfg_wr_en,
    input  logic [bbrm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbrm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic              in_valid_reg;
    bbrm_pkg::snap_t   in_data_reg;
    logic              out_valid_reg;
    bbrm_pkg::report_t out_data_reg;
    bbrm_pkg::report_t out_data_next;
    bbrm_pkg::cfg_t    cfg_reg;
    logic [3:0]        active;
    logic              pipe_adv;

    assign pipe_adv       = !out_valid_reg || report.ready;
    assign snapshot.ready = !in_valid_reg || pipe_adv;
    assign report.valid   = out_valid_reg;
    assign report.data    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ban_parasol_dash <= 1'b1;
            cfg_reg.ban_slight_side  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bbrm_pkg::CFG_BAN_PARASOL_DASH: cfg_reg.ban_parasol_dash <= cfg_wdata[0];
                bbrm_pkg::CFG_BAN_SLIGHT_SIDE:  cfg_reg.ban_slight_side  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snapshot.ready)
                in_valid_reg <= snapshot.valid;
            if (pipe_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snapshot.valid && snapshot.ready)
            in_data_reg <= snapshot.data;
        if (pipe_adv && in_valid_reg)
            out_data_reg <= out_data_next;
    end

    bbrm_lockout u_lockout (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (pipe_adv && in_valid_reg),
        .directions (in_data_reg.directions),
        .active     (active)
    );

    bbrm_mapper u_mapper (
        .active (active),
        .snap   (in_data_reg),
        .cfg    (cfg_reg),
        .report (out_data_next)
    );

`ifndef SYNTH
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_adv && in_valid_reg) |=> out_valid_reg)
        else $error("Advancing request did not reach the output register.");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !pipe_adv) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("Held request in the input register was overwritten.");

    a_trigger_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.trigger_right != 8'd0)
                           == out_data_reg.report_buttons[6]))
        else $error("Right trigger level disagrees with the R button bit.");
`endif

endmodule
